@@ sv/bhv_pkg.sv @@
package bhv_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bhv_in_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] image_width;
    logic signed [31:0] image_height;
    logic [15:0]        pixel_depth;
    logic [31:0]        palette_entries;
    logic [31:0]        pixel_offset;
  } bhv_out_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SIGNATURE   = 4'd1,
    ST_SIZE        = 4'd2,
    ST_RESERVED    = 4'd3,
    ST_VERSION     = 4'd4,
    ST_WIDTH       = 4'd5,
    ST_HEIGHT      = 4'd6,
    ST_PLANES      = 4'd7,
    ST_DEPTH       = 4'd8,
    ST_COMPRESSION = 4'd9,
    ST_PIXEL_SIZE  = 4'd10,
    ST_NO_COLOURS  = 4'd11,
    ST_MANY_COLOURS = 4'd12,
    ST_TRUE_COLOUR = 4'd13,
    ST_MANY_IMPORTANT = 4'd14
  } bhv_status_t;

  // Byte positions at which a field is complete.
  localparam logic [5:0] POS_SIGNATURE   = 6'd1;
  localparam logic [5:0] POS_DECL_SIZE   = 6'd5;
  localparam logic [5:0] POS_RESERVED    = 6'd9;
  localparam logic [5:0] POS_OFFSET      = 6'd13;
  localparam logic [5:0] POS_HDR_SIZE    = 6'd17;
  localparam logic [5:0] POS_WIDTH       = 6'd21;
  localparam logic [5:0] POS_HEIGHT      = 6'd25;
  localparam logic [5:0] POS_PLANES      = 6'd27;
  localparam logic [5:0] POS_DEPTH       = 6'd29;
  localparam logic [5:0] POS_COMPRESSION = 6'd33;
  localparam logic [5:0] POS_IMAGE_SIZE  = 6'd37;
  localparam logic [5:0] POS_COLOURS     = 6'd49;
  localparam logic [5:0] POS_IMPORTANT   = 6'd53;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [31:0] MAX_PALETTE   = 32'd256;
  localparam logic [15:0] DEPTH_TRUE    = 16'd24;
  localparam logic [15:0] DEPTH_INDEXED = 16'd8;

endpackage

@@ sv/bmp_header_validator.sv @@
// Checks the 54-byte BMP file header and info header, one byte per item, at one item per
// clock when not stalled. An item passes an input register and then the field logic, so a
// result is held in the result register after the byte that decides it has passed both. The
// input stalls only while the input register holds a byte and the result register is full
// and stalled. The first failing field, or success at byte 53, gives one result item
// carrying the status and the fields read so far (zero where not yet read). A byte with
// start_of_file set begins a new file; bytes after a result, or before any start, are
// taken and ignored. Write file_length while the block is idle.
module bmp_header_validator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  bhv_pkg::bhv_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output bhv_pkg::bhv_out_t out_item
);
  import bhv_pkg::*;

  logic [31:0] file_length_r;

  logic    s1_valid_r, s1_valid_nxt;
  bhv_in_t s1_r;

  logic        finished_r, finished_nxt;
  logic [5:0]  pos_r, pos_nxt, pos_eff;
  logic [31:0] shift_r, shift_nxt, shift_eff;
  logic [31:0] declared_r, declared_nxt, declared_eff;
  logic [31:0] offset_r, offset_nxt, offset_eff;
  logic [31:0] width_r, width_nxt, width_eff;
  logic [31:0] height_r, height_nxt, height_eff;
  logic [15:0] depth_r, depth_nxt, depth_eff;
  logic [31:0] colours_r, colours_nxt, colours_eff;
  logic        fin_eff;

  logic        out_valid_r, out_valid_nxt;
  bhv_out_t    out_r;

  logic        fire;
  logic        hit;
  bhv_status_t status;
  logic [15:0] w16;
  logic [31:0] pixel_bytes;

  assign fire     = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_comb begin
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    fin_eff      = s1_r.start_of_file ? 1'b0  : finished_r;
    pos_eff      = s1_r.start_of_file ? 6'd0  : pos_r;
    shift_eff    = s1_r.start_of_file ? 32'd0 : shift_r;
    declared_eff = s1_r.start_of_file ? 32'd0 : declared_r;
    offset_eff   = s1_r.start_of_file ? 32'd0 : offset_r;
    width_eff    = s1_r.start_of_file ? 32'd0 : width_r;
    height_eff   = s1_r.start_of_file ? 32'd0 : height_r;
    depth_eff    = s1_r.start_of_file ? 16'd0 : depth_r;
    colours_eff  = s1_r.start_of_file ? 32'd0 : colours_r;

    shift_nxt    = {s1_r.data_byte, shift_eff[31:8]};
    w16          = shift_nxt[31:16];
    pixel_bytes  = declared_eff - offset_eff;

    pos_nxt      = pos_eff;
    declared_nxt = declared_eff;
    offset_nxt   = offset_eff;
    width_nxt    = width_eff;
    height_nxt   = height_eff;
    depth_nxt    = depth_eff;
    colours_nxt  = colours_eff;
    hit          = 1'b0;
    status       = ST_OK;

    if (!fin_eff) begin
      case (pos_eff)
        POS_SIGNATURE: begin
          if (w16 != BMP_SIGNATURE) begin
            hit = 1'b1;
            status = ST_SIGNATURE;
          end
        end
        POS_DECL_SIZE: begin
          declared_nxt = shift_nxt;
          if (shift_nxt != file_length_r) begin
            hit = 1'b1;
            status = ST_SIZE;
          end
        end
        POS_RESERVED: begin
          if (shift_nxt != 32'd0) begin
            hit = 1'b1;
            status = ST_RESERVED;
          end
        end
        POS_OFFSET: begin
          offset_nxt = shift_nxt;
        end
        POS_HDR_SIZE: begin
          if (shift_nxt != INFO_HDR_SIZE) begin
            hit = 1'b1;
            status = ST_VERSION;
          end
        end
        POS_WIDTH: begin
          width_nxt = shift_nxt;
          if (shift_nxt == 32'd0 || shift_nxt[31]) begin
            hit = 1'b1;
            status = ST_WIDTH;
          end
        end
        POS_HEIGHT: begin
          height_nxt = shift_nxt;
          if (shift_nxt == 32'd0) begin
            hit = 1'b1;
            status = ST_HEIGHT;
          end
        end
        POS_PLANES: begin
          if (w16 != 16'd1) begin
            hit = 1'b1;
            status = ST_PLANES;
          end
        end
        POS_DEPTH: begin
          depth_nxt = w16;
          if (w16 != DEPTH_INDEXED && w16 != DEPTH_TRUE) begin
            hit = 1'b1;
            status = ST_DEPTH;
          end
        end
        POS_COMPRESSION: begin
          if (shift_nxt != 32'd0) begin
            hit = 1'b1;
            status = ST_COMPRESSION;
          end
        end
        POS_IMAGE_SIZE: begin
          if (shift_nxt != 32'd0 && shift_nxt != pixel_bytes) begin
            hit = 1'b1;
            status = ST_PIXEL_SIZE;
          end
        end
        POS_COLOURS: begin
          colours_nxt = shift_nxt;
          if (depth_eff == DEPTH_INDEXED && shift_nxt == 32'd0) begin
            hit = 1'b1;
            status = ST_NO_COLOURS;
          end else if (depth_eff == DEPTH_INDEXED && shift_nxt > MAX_PALETTE) begin
            hit = 1'b1;
            status = ST_MANY_COLOURS;
          end else if (depth_eff == DEPTH_TRUE && shift_nxt != 32'd0) begin
            hit = 1'b1;
            status = ST_TRUE_COLOUR;
          end
        end
        POS_IMPORTANT: begin
          hit = 1'b1;
          if (depth_eff == DEPTH_INDEXED && shift_nxt > MAX_PALETTE) begin
            status = ST_MANY_IMPORTANT;
          end else begin
            status = ST_OK;
          end
        end
        default: begin
        end
      endcase
      if (pos_eff < POS_IMPORTANT) begin
        pos_nxt = pos_eff + 6'd1;
      end
    end
    finished_nxt = fin_eff || hit;
  end

  always_comb begin
    if (fire && hit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= 32'd0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      finished_r    <= 1'b1;
      pos_r         <= 6'd0;
      shift_r       <= 32'd0;
      declared_r    <= 32'd0;
      offset_r      <= 32'd0;
      width_r       <= 32'd0;
      height_r      <= 32'd0;
      depth_r       <= 16'd0;
      colours_r     <= 32'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        file_length_r <= cfg_wr_data;
      end
      if (fire) begin
        finished_r <= finished_nxt;
        pos_r      <= pos_nxt;
        declared_r <= declared_nxt;
        offset_r   <= offset_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        depth_r    <= depth_nxt;
        colours_r  <= colours_nxt;
        if (!fin_eff) begin
          shift_r <= shift_nxt;
        end else begin
          shift_r <= shift_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_item;
    end
    if (fire && hit) begin
      out_r.status          <= status;
      out_r.image_width     <= width_nxt;
      out_r.image_height    <= height_nxt;
      out_r.pixel_depth     <= depth_nxt;
      out_r.palette_entries <= colours_nxt;
      out_r.pixel_offset    <= offset_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_result_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hit |=> finished_r && out_valid_r)
    else $error("result item given without ending the file");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_IMPORTANT)
    else $error("byte position ran past the header");

  a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_OK |->
      out_r.pixel_depth == DEPTH_INDEXED || out_r.pixel_depth == DEPTH_TRUE)
    else $error("success reported with an unsupported depth");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && s1_valid_r)
    else $error("input stalled with free output register");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && finished_r && !s1_r.start_of_file |-> !hit)
    else $error("result item produced while idle");
`endif

endmodule
